FILE: rtl/ptc_pkg.sv
package ptc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam int TEMP_REF    = 2000;
	localparam int TEMP_VLOW   = -1500;
	localparam int TEST_OFFSET = 100000;

	localparam logic signed [31:0] P_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] P_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_C1 = 3'd0,
		CFG_C2 = 3'd1,
		CFG_C3 = 3'd2,
		CFG_C4 = 3'd3,
		CFG_C5 = 3'd4,
		CFG_C6 = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
	} cfg_t;

	// temperature branch of the second-order correction
	typedef enum logic [1:0] {
		CLS_HIGH,
		CLS_LOW,
		CLS_VLOW
	} cls_t;

	typedef struct packed {
		logic [23:0]        d1;
		logic               test;
		cls_t               cls;
		logic signed [18:0] temp;
		logic signed [18:0] tm20;
		logic signed [18:0] tp15;
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic [17:0]        ti;
	} front_item_t;

endpackage

FILE: rtl/ptc_in_if.sv
interface ptc_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] raw_pressure;
	logic [23:0] raw_temperature;
	logic        submerge_test;

	modport source (output valid, output raw_pressure, output raw_temperature,
		output submerge_test, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature,
		input submerge_test, output ready);
endinterface

FILE: rtl/ptc_out_if.sv
interface ptc_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] temperature_centi_c;
	logic signed [31:0] pressure_tenth_mbar;

	modport source (output valid, output temperature_centi_c,
		output pressure_tenth_mbar, input ready);
	modport sink (input valid, input temperature_centi_c,
		input pressure_tenth_mbar, output ready);
endinterface

FILE: rtl/ptc_cfg_if.sv
interface ptc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ptc_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ptc_cfg_regs.sv
module ptc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	ptc_cfg_if.sink       cfg,
	output ptc_pkg::cfg_t coef
);
	ptc_pkg::cfg_t coef_q;

	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			case (ptc_pkg::cfg_idx_t'(cfg.index))
				ptc_pkg::CFG_C1: coef_q.c1 <= cfg.data;
				ptc_pkg::CFG_C2: coef_q.c2 <= cfg.data;
				ptc_pkg::CFG_C3: coef_q.c3 <= cfg.data;
				ptc_pkg::CFG_C4: coef_q.c4 <= cfg.data;
				ptc_pkg::CFG_C5: coef_q.c5 <= cfg.data;
				ptc_pkg::CFG_C6: coef_q.c6 <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/ptc_front.sv
module ptc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ptc_in_if.sink               sample,
	input  ptc_pkg::cfg_t        coef,
	output ptc_pkg::front_item_t item,
	output logic                 item_valid,
	input  logic                 item_ready
);
	logic en;
	logic v_s1, v_s2, v_s3;

	logic [23:0]        d1_s1, d1_s2;
	logic               test_s1, test_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] m6_s2, m4_s2, m3_s2;
	logic [48:0]        sq_s2;
	ptc_pkg::front_item_t item_s3;

	logic signed [24:0] dt_c;
	logic signed [16:0] c6s, c4s, c3s;
	logic signed [41:0] m6_c, m4_c, m3_c;
	logic signed [49:0] sq_c;

	logic signed [18:0] tsh;
	logic signed [18:0] temp_c;
	logic [50:0]        sq3;
	ptc_pkg::front_item_t item_c;

	// shift when the last stage is empty or the queue takes it
	assign en           = !v_s3 || item_ready;
	assign sample.ready = en;
	assign item         = item_s3;
	assign item_valid   = v_s3;

	// S1: dT = D2 - C5*256
	assign dt_c = signed'({1'b0, sample.raw_temperature}) - signed'({1'b0, coef.c5, 8'h00});

	// S2: the four products of dT
	assign c6s  = signed'({1'b0, coef.c6});
	assign c4s  = signed'({1'b0, coef.c4});
	assign c3s  = signed'({1'b0, coef.c3});
	assign m6_c = 42'(dt_s1) * 42'(c6s);
	assign m4_c = 42'(dt_s1) * 42'(c4s);
	assign m3_c = 42'(dt_s1) * 42'(c3s);
	assign sq_c = 50'(dt_s1) * 50'(dt_s1);

	// S3: first-order terms, branch, Ti
	assign tsh    = signed'(m6_s2[41:23]);
	assign temp_c = tsh + 19'(ptc_pkg::TEMP_REF);
	assign sq3    = {2'b00, sq_s2} + {1'b0, sq_s2, 1'b0};

	always_comb begin
		item_c      = '0;
		item_c.d1   = d1_s2;
		item_c.test = test_s2;
		item_c.temp = temp_c;
		item_c.tm20 = tsh;
		item_c.tp15 = temp_c - 19'(ptc_pkg::TEMP_VLOW);
		item_c.off  = signed'({4'b0, coef.c2, 16'h0000}) + 36'(signed'(m4_s2[41:7]));
		item_c.sens = signed'({4'b0, coef.c1, 15'h0000}) + 35'(signed'(m3_s2[41:8]));
		if (temp_c < 19'(ptc_pkg::TEMP_REF)) begin
			item_c.ti = sq3[50:33];
			if (temp_c < 19'(ptc_pkg::TEMP_VLOW)) begin
				item_c.cls = ptc_pkg::CLS_VLOW;
			end else begin
				item_c.cls = ptc_pkg::CLS_LOW;
			end
		end else begin
			item_c.ti  = 18'(sq_s2[48:36]);
			item_c.cls = ptc_pkg::CLS_HIGH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= sample.raw_pressure;
			test_s1 <= sample.submerge_test;
			dt_s1   <= dt_c;
			d1_s2   <= d1_s1;
			test_s2 <= test_s1;
			m6_s2   <= m6_c;
			m4_s2   <= m4_c;
			m3_s2   <= m3_c;
			sq_s2   <= sq_c[48:0];
			item_s3 <= item_c;
		end
	end
endmodule

FILE: rtl/ptc_fifo.sv
module ptc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptc_pkg::front_item_t push_item,
	input  logic                 push_valid,
	output logic                 push_ready,
	output ptc_pkg::front_item_t pop_item,
	output logic                 pop_valid,
	input  logic                 pop_ready
);
	ptc_pkg::front_item_t          mem_q [ptc_pkg::QDEPTH];
	logic [ptc_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [ptc_pkg::QPTR_W:0]      cnt_q;
	logic                          push, pop;

	assign push_ready = cnt_q != (ptc_pkg::QPTR_W+1)'(ptc_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not rise on push");
	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not fall on pop");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with unequal pointers");
endmodule

FILE: rtl/ptc_back.sv
module ptc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptc_pkg::front_item_t item,
	input  logic                 item_valid,
	output logic                 item_ready,
	ptc_out_if.source            result
);
	logic en;
	logic v_b1, v_b2, v_b3, v_b4, v_b5, v_out_q;

	ptc_pkg::front_item_t it_b1, it_b2;
	logic [34:0]        sqm_b1, sqp_b1;
	logic [38:0]        offi_b2;
	logic [37:0]        sensi_b2;
	logic [23:0]        d1_b3;
	logic               test_b3, test_b4, test_b5;
	logic signed [39:0] off2_b3, off2_b4;
	logic signed [39:0] sens2_b3;
	logic signed [19:0] t2_b3, t2_b4, t2_b5;
	logic [44:0]        pl_b4;
	logic signed [43:0] ph_b4;
	logic signed [45:0] y_b5;
	logic signed [18:0] temp_q;
	logic signed [31:0] pres_q;

	logic signed [37:0] sqm_c, sqp_c;
	logic [36:0]        m3x;
	logic [37:0]        m5x, p7;
	logic [38:0]        offi_c;
	logic [37:0]        sensi_c;
	logic signed [33:0] pt;
	logic signed [31:0] pres_c;

	assign en                  = !v_out_q || result.ready;
	assign item_ready          = en;
	assign result.valid        = v_out_q;
	assign result.temperature_centi_c = temp_q;
	assign result.pressure_tenth_mbar = pres_q;

	// B1: squares of (TEMP-2000) and (TEMP+1500)
	assign sqm_c = 38'(item.tm20) * 38'(item.tm20);
	assign sqp_c = 38'(item.tp15) * 38'(item.tp15);

	// B2: OFFi, SENSi per branch
	assign m3x = {1'b0, sqm_b1, 1'b0} + {2'b00, sqm_b1};
	assign m5x = {1'b0, sqm_b1, 2'b00} + {3'b000, sqm_b1};
	assign p7  = {sqp_b1, 3'b000} - {3'b000, sqp_b1};

	always_comb begin
		case (it_b1.cls)
			ptc_pkg::CLS_LOW: begin
				offi_c  = 39'(m3x[36:1]);
				sensi_c = 38'(m5x[37:3]);
			end
			ptc_pkg::CLS_VLOW: begin
				offi_c  = 39'(m3x[36:1]) + 39'(p7);
				sensi_c = 38'(m5x[37:3]) + {1'b0, sqp_b1, 2'b00};
			end
			default: begin
				offi_c  = 39'(sqm_b1[34:4]);
				sensi_c = '0;
			end
		endcase
	end

	// B6: final shift, test offset, saturation
	assign pt = 34'(signed'(y_b5[45:13]))
		+ (test_b5 ? 34'(ptc_pkg::TEST_OFFSET) : 34'sd0);

	always_comb begin
		if (pt > 34'(ptc_pkg::P_MAX)) begin
			pres_c = ptc_pkg::P_MAX;
		end else if (pt < 34'(ptc_pkg::P_MIN)) begin
			pres_c = ptc_pkg::P_MIN;
		end else begin
			pres_c = pt[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1    <= 1'b0;
			v_b2    <= 1'b0;
			v_b3    <= 1'b0;
			v_b4    <= 1'b0;
			v_b5    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_b1    <= item_valid;
			v_b2    <= v_b1;
			v_b3    <= v_b2;
			v_b4    <= v_b3;
			v_b5    <= v_b4;
			v_out_q <= v_b5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_b1    <= item;
			sqm_b1   <= sqm_c[34:0];
			sqp_b1   <= sqp_c[34:0];
			it_b2    <= it_b1;
			offi_b2  <= offi_c;
			sensi_b2 <= sensi_c;
			// B3: second-order OFF2, SENS2, T2
			d1_b3    <= it_b2.d1;
			test_b3  <= it_b2.test;
			off2_b3  <= 40'(it_b2.off) - signed'({1'b0, offi_b2});
			sens2_b3 <= 40'(it_b2.sens) - signed'({2'b00, sensi_b2});
			t2_b3    <= 20'(it_b2.temp) - signed'({2'b00, it_b2.ti});
			// B4: D1*SENS2 as two partial products
			test_b4  <= test_b3;
			off2_b4  <= off2_b3;
			t2_b4    <= t2_b3;
			pl_b4    <= 45'(d1_b3) * 45'(sens2_b3[20:0]);
			ph_b4    <= 44'(signed'({1'b0, d1_b3})) * 44'(signed'(sens2_b3[39:21]));
			// B5: floor(D1*SENS2 / 2^21) - OFF2
			test_b5  <= test_b4;
			t2_b5    <= t2_b4;
			y_b5     <= 46'(ph_b4) + 46'(signed'({1'b0, pl_b4[44:21]})) - 46'(off2_b4);
			temp_q   <= t2_b5[18:0];
			pres_q   <= pres_c;
		end
	end
endmodule

FILE: rtl/pressure_temp_compensation.sv
// Second-order temperature compensation for a barometric sensor.
// sample: one request carries raw pressure D1, raw temperature D2 and the
//   submerge test bit; accepted when valid and ready are both high.
// result: temperature in 0.01 degC and pressure in 0.1 mbar, saturated
//   to signed 32 bits, plus 10 bar when the test bit was set.
// cfg: writes calibration words C1..C6 at index 0..5; always ready.
//   Write only while no request is in flight.
// Structure: a three-stage front computes dT, TEMP, OFF, SENS, Ti and
//   picks the high / low / very-low branch; a four-entry queue feeds a
//   six-stage back end with the squares, corrections and D1*SENS2.
// Throughput: one request per cycle while sample.ready is high. From the
//   accepting edge to result valid there are ten register stages (3 front,
//   1 queue, 6 back; the accepting edge loads the first).
// Stall: when result.ready is low the back end holds; the queue absorbs
//   the front, and sample.ready drops once the queue is full.
// Reset: clears all valid bits, queue pointers and the calibration words
//   to zero; no result is pending after reset.
module pressure_temp_compensation (
	input  logic      clk,
	input  logic      arst_n,
	ptc_in_if.sink    sample,
	ptc_out_if.source result,
	ptc_cfg_if.sink   cfg
);
	ptc_pkg::cfg_t        coef;
	ptc_pkg::front_item_t f_item, q_item;
	logic                 f_valid, f_ready;
	logic                 q_valid, q_ready;

	// calibration words
	ptc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	// first-order terms and branch select
	ptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.coef       (coef),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	// decouples the front from output stalls
	ptc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_item   (q_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	// second-order correction, pressure, output register
	ptc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.result     (result)
	);
endmodule

FILE: tb/sv/tb_ifs.sv
// Channel interfaces are provided with the RTL (ptc_in_if, ptc_out_if, ptc_cfg_if).
// This file holds the testbench's shared record type for an expected result.
package tb_ptc_pkg;
	typedef struct {
		logic signed [18:0] temp;
		logic signed [31:0] pres;
	} ptc_expect_t;
endpackage

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptc_in_if  sample ();
	ptc_out_if result ();
	ptc_cfg_if cfg ();

	pressure_temp_compensation DUT (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result), .cfg(cfg)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the calibration words
	logic [15:0] cal [6];
	tb_ptc_pkg::ptc_expect_t expected_q [$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// floor shift: SV >>> on signed operands already floors
	function automatic tb_ptc_pkg::ptc_expect_t compensate(input logic [23:0] d1,
			input logic [23:0] d2, input logic tst);
		longint dt, t, tm, off, sens, ti, offi, sensi, tp, p;
		tb_ptc_pkg::ptc_expect_t r;
		dt = longint'(d2) - longint'(cal[ptc_pkg::CFG_C5]) * 256;
		t = ptc_pkg::TEMP_REF + ((dt * longint'(cal[ptc_pkg::CFG_C6])) >>> 23);
		tm = t - ptc_pkg::TEMP_REF;
		off = longint'(cal[ptc_pkg::CFG_C2]) * 65536
			+ ((longint'(cal[ptc_pkg::CFG_C4]) * dt) >>> 7);
		sens = longint'(cal[ptc_pkg::CFG_C1]) * 32768
			+ ((longint'(cal[ptc_pkg::CFG_C3]) * dt) >>> 8);
		if (t < ptc_pkg::TEMP_REF) begin
			ti = (3 * dt * dt) >>> 33;
			offi = (3 * tm * tm) >>> 1;
			sensi = (5 * tm * tm) >>> 3;
			if (t < ptc_pkg::TEMP_VLOW) begin
				tp = t + 1500;
				offi += 7 * tp * tp;
				sensi += 4 * tp * tp;
			end
		end else begin
			ti = (2 * dt * dt) >>> 37;
			offi = (tm * tm) >>> 4;
			sensi = 0;
		end
		p = (((longint'(d1) * (sens - sensi)) >>> 21) - (off - offi)) >>> 13;
		if (tst)
			p += ptc_pkg::TEST_OFFSET;
		if (p > longint'(ptc_pkg::P_MAX))
			p = ptc_pkg::P_MAX;
		if (p < longint'(ptc_pkg::P_MIN))
			p = ptc_pkg::P_MIN;
		r.temp = 19'(t - ti);
		r.pres = 32'(p);
		return r;
	endfunction

	// one request on the sample channel, with random idle before it
	task automatic send_sample(input logic [23:0] d1, input logic [23:0] d2, input logic tst);
		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.raw_pressure <= d1;
		sample.raw_temperature <= d2;
		sample.submerge_test <= tst;
		do
			@(posedge clk);
		while (!sample.ready);
		expected_q.push_back(compensate(d1, d2, tst));
		sent++;
	endtask

	// block is idle only after all results drain plus pipeline latency
	task automatic drain();
		sample.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cal(input ptc_pkg::cfg_idx_t idx, input logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		cal[idx] = val;
	endtask

	task automatic load_cal(input logic [15:0] v1, v2, v3, v4, v5, v6);
		drain();
		write_cal(ptc_pkg::CFG_C1, v1);
		write_cal(ptc_pkg::CFG_C2, v2);
		write_cal(ptc_pkg::CFG_C3, v3);
		write_cal(ptc_pkg::CFG_C4, v4);
		write_cal(ptc_pkg::CFG_C5, v5);
		write_cal(ptc_pkg::CFG_C6, v6);
		cfg.valid <= 1'b0;
	endtask

	// receiver: random stalls, checks each result against oldest prediction
	always @(posedge clk) begin
		tb_ptc_pkg::ptc_expect_t e;
		cycles++;
		if (result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", 64'(result.pressure_tenth_mbar), 64'd0);
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (result.temperature_centi_c !== e.temp)
					report("temperature", 64'(result.temperature_centi_c), 64'(e.temp));
				if (result.pressure_tenth_mbar !== e.pres)
					report("pressure", 64'(result.pressure_tenth_mbar), 64'(e.pres));
			end
		end
		result.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (cycles > 400000) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// zero calibration after reset, then corners of the raw readings
	task automatic test_zero_cal();
		send_sample(24'h0, 24'h0, 1'b0);
		send_sample(24'hffffff, 24'hffffff, 1'b1);
	endtask

	// typical datasheet-like coefficients: high, low and very-low branches
	task automatic test_branches();
		load_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
		send_sample(24'd4958179, 24'd6815414, 1'b0);   // near 20 degC
		send_sample(24'd4958179, 24'd8000000, 1'b0);   // high temperature
		send_sample(24'd4958179, 24'd6000000, 1'b0);   // low temperature
		send_sample(24'd4958179, 24'd1000000, 1'b0);   // very low temperature
		send_sample(24'd4958179, 24'd6815414, 1'b1);   // test offset
		send_sample(24'hffffff, 24'h0, 1'b1);
		send_sample(24'h0, 24'hffffff, 1'b0);
	endtask

	// extreme calibration words (all ones, then mixed) with corner raw readings
	task automatic test_saturation();
		load_cal(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_sample(24'hffffff, 24'hffffff, 1'b1);
		send_sample(24'hffffff, 24'h0, 1'b0);
		send_sample(24'h0, 24'h0, 1'b1);
		send_sample(24'h0, 24'hffffff, 1'b0);
		load_cal(16'hffff, 16'h0, 16'hffff, 16'h0, 16'h0, 16'hffff);
		send_sample(24'hffffff, 24'hffffff, 1'b1);
		send_sample(24'h800000, 24'h7fffff, 1'b0);
	endtask

	// random readings under several flow-control mixes and random calibration
	task automatic test_random();
		int idle_a [4] = '{0, 55, 0, 32};
		int stall_a [4] = '{0, 0, 55, 32};
		for (int ph = 0; ph < 4; ph++) begin
			load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
			send_idle_pct = idle_a[ph];
			recv_stall_pct = stall_a[ph];
			for (int i = 0; i < 150; i++)
				send_sample(24'($urandom), 24'($urandom), 1'($urandom_range(1)));
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.raw_pressure = '0;
		sample.raw_temperature = '0;
		sample.submerge_test = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = ptc_pkg::CFG_C1;
		cfg.data = '0;
		result.ready = 1'b1;
		for (int i = 0; i < 6; i++)
			cal[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_cal();
		test_branches();
		test_saturation();
		test_random();
		drain();
		$display("Sent %0d samples, checked %0d results across branch, saturation and",
			sent, checked);
		$display("random calibration phases with sender idling and receiver stalls.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/ptc_pkg.sv
rtl/ptc_in_if.sv
rtl/ptc_out_if.sv
rtl/ptc_cfg_if.sv
rtl/ptc_cfg_regs.sv
rtl/ptc_front.sv
rtl/ptc_fifo.sv
rtl/ptc_back.sv
rtl/pressure_temp_compensation.sv
tb/sv/tb_ifs.sv
tb/sv/tb_top.sv
